[hdl/cas_pid_pkg.sv]
// Shared types and constants for the cascade angle/speed PID block.
// No dependencies; imported by every module of the block.
package cas_pid_pkg;

  localparam int ANG_W    = 27;   // angle input width
  localparam int SPD_W    = 32;   // speed input / drive width
  localparam int ST_W     = 26;   // speed target width
  localparam int GAIN_W   = 48;
  localparam int LIM_W    = 31;
  localparam int INT_W    = 48;
  localparam int EA_W     = 29;   // unwrapped angle error width
  localparam int CHUNK_G  = 24;   // gain slice per product
  localparam int CHUNK_M  = 32;   // magnitude slice per product
  localparam int PP_W     = CHUNK_G + CHUNK_M;
  localparam int ACC_W    = 100;  // three 96-bit terms plus sign
  localparam int VAL_W    = ACC_W - 32;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_STEPS = 8;
  localparam logic [2:0] STEP_LAST = 3'(MUL_STEPS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM = 3'd7;

  localparam logic [GAIN_W-1:0] RST_ANGLE_KP = 48'd193273528320;
  localparam logic [GAIN_W-1:0] RST_ANGLE_KI = 48'd215;
  localparam logic [GAIN_W-1:0] RST_ANGLE_KD = 48'd53687091200;
  localparam logic [LIM_W-1:0]  RST_ANGLE_LIM = 31'd655360000;
  localparam logic [GAIN_W-1:0] RST_SPEED_KP = 48'd236223201280;
  localparam logic [GAIN_W-1:0] RST_SPEED_KI = 48'd2147;
  localparam logic [GAIN_W-1:0] RST_SPEED_KD = 48'd64424509440;
  localparam logic [LIM_W-1:0]  RST_SPEED_LIM = 31'd655360000;

  localparam logic signed [27:0] DEG180 = 28'sd11796480;   // 180.0
  localparam logic signed [EA_W-1:0] DEG360 = 29'sd23592960; // 360.0
  localparam logic signed [ST_W-1:0]  SPD_LIM = 26'sd22937600;    // 350.0
  localparam logic signed [SPD_W-1:0] DRV_LIM = 32'sd1638400000;  // 25000.0

  typedef struct packed {
    logic       accept;    // latch input request
    logic       prep;      // form error, derivative, integral for loop
    logic       loop;      // 0 = angle loop, 1 = speed loop
    logic       mul_en;    // issue one partial product
    logic [2:0] step;      // partial product index
    logic       round;     // round, clamp and store loop output
    logic       load_out;  // move results to output register
  } cp_cmd_t;

endpackage

[hdl/cascade_angle_speed_pid.sv]
// Top level of the cascade angle/speed PID controller.
// Depends on cas_pid_pkg, cas_pid_ctrl and cas_pid_dp.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+----------------
//  input   | in_target_angle, in_measured_angle,           | in_valid/in_stall
//          | in_measured_speed                             |
//  result  | out_drive, out_speed_target                   | out_valid/out_stall
//  config  | cfg_index, cfg_data                           | cfg_we
//
// Each accepted request runs the angle loop, then the speed loop, each through prep,
// eight partial products, drain and round: sixteen partial products on the one 24x32
// multiplier in all. Then the output register is loaded, and only after that load is
// the next request taken.
// Synchronous active-low reset restores gains and clears errors and integrals.
// A held result stalls only the final load; the next input is taken meanwhile, but not while that load waits.
module cascade_angle_speed_pid import cas_pid_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ANG_W-1:0] in_target_angle,
  input  logic signed [ANG_W-1:0] in_measured_angle,
  input  logic signed [SPD_W-1:0] in_measured_speed,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SPD_W-1:0] out_drive,
  output logic signed [ST_W-1:0]  out_speed_target,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data
);

  cp_cmd_t cmd;

  cas_pid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cas_pid_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_target_angle   (in_target_angle),
    .in_measured_angle (in_measured_angle),
    .in_measured_speed (in_measured_speed),
    .out_drive         (out_drive),
    .out_speed_target  (out_speed_target)
  );

  // an accepted request keeps the input side busy while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after accept");

  a_st_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_speed_target <= SPD_LIM && out_speed_target >= -SPD_LIM))
    else $error("speed target outside clamp");

  a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= DRV_LIM && out_drive >= -DRV_LIM))
    else $error("drive outside clamp");

  // a new result appears only when the sequencer finishes both loops
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while idle");

endmodule

[hdl/cas_pid_ctrl.sv]
// Sequencer for the cascade PID: walks both loops through prep, eight
// products, drain and round. Depends on cas_pid_pkg.
module cas_pid_ctrl import cas_pid_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_DRAIN, S_ROUND, S_OUT
  } state_t;

  state_t     state_r;
  logic       loop_r;
  logic [2:0] step_r;
  logic       out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.loop     = loop_r;
    cmd.step     = step_r;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.prep     = (state_r == S_PREP);
    cmd.mul_en   = (state_r == S_MUL);
    cmd.round    = (state_r == S_ROUND);
    cmd.load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loop_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            loop_r  <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          step_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          step_r <= step_r + 3'd1;
          if (step_r == STEP_LAST) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= S_ROUND;
        S_ROUND: begin
          if (!loop_r) begin
            loop_r  <= 1'b1;
            state_r <= S_PREP;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (cmd.load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

[hdl/cas_pid_dp.sv]
// Datapath for the cascade PID: config registers, loop state, one shared
// 24x32 multiplier, 100-bit accumulator, rounding and clamping.
// Depends on cas_pid_pkg; driven by cas_pid_ctrl commands.
module cas_pid_dp import cas_pid_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cp_cmd_t                     cmd,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [GAIN_W-1:0]           cfg_data,
  input  logic signed [ANG_W-1:0]     in_target_angle,
  input  logic signed [ANG_W-1:0]     in_measured_angle,
  input  logic signed [SPD_W-1:0]     in_measured_speed,
  output logic signed [SPD_W-1:0]     out_drive,
  output logic signed [ST_W-1:0]      out_speed_target
);

  // configuration
  logic [GAIN_W-1:0] a_kp_r, a_ki_r, a_kd_r, s_kp_r, s_ki_r, s_kd_r;
  logic [LIM_W-1:0]  a_lim_r, s_lim_r;

  // loop state
  logic signed [EA_W-1:0]  prev_a_r;
  logic signed [SPD_W-1:0] prev_s_r;
  logic signed [INT_W-1:0] integ_a_r, integ_s_r;

  // working registers
  logic signed [ANG_W-1:0] tgt_r, meas_r;
  logic signed [SPD_W-1:0] spd_r;
  logic signed [SPD_W-1:0] e_r;
  logic signed [SPD_W:0]   d_r;
  logic signed [INT_W-1:0] i_r;
  logic [PP_W-1:0]         pp_r;
  logic                    pp_vld_r, pp_neg_r, pp_ghi_r, pp_mhi_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ST_W-1:0]  st_r;
  logic signed [SPD_W-1:0] dr_r;
  logic signed [SPD_W-1:0] out_drive_r;
  logic signed [ST_W-1:0]  out_st_r;

  // angle unwrap and error
  logic signed [27:0]      gap;
  logic signed [EA_W-1:0]  meas_adj, ea;
  always_comb begin
    gap      = 28'(tgt_r) - 28'(meas_r);
    meas_adj = EA_W'(meas_r);
    if (gap >= DEG180) meas_adj = meas_adj + DEG360;
    else if (gap <= -DEG180) meas_adj = meas_adj - DEG360;
    ea = EA_W'(tgt_r) - meas_adj;
  end

  // speed error, saturated to 32 bits
  logic signed [SPD_W:0]   es_w;
  logic signed [SPD_W-1:0] es;
  always_comb begin
    es_w = (SPD_W+1)'(st_r) - (SPD_W+1)'(spd_r);
    case (es_w[SPD_W:SPD_W-1])
      2'b01:   es = {1'b0, {(SPD_W-1){1'b1}}};
      2'b10:   es = {1'b1, {(SPD_W-1){1'b0}}};
      default: es = es_w[SPD_W-1:0];
    endcase
  end

  // per-loop error, derivative and integral
  logic signed [SPD_W-1:0] e_n, prev_sel;
  logic signed [SPD_W:0]   d_n;
  logic signed [INT_W-1:0] i_sel, i_n, lim_s;
  logic signed [INT_W:0]   i_sum;
  logic                    e_pos, hold;
  always_comb begin
    if (cmd.loop) begin
      e_n      = es;
      prev_sel = prev_s_r;
      i_sel    = integ_s_r;
      lim_s    = $signed({{(INT_W-LIM_W){1'b0}}, s_lim_r});
    end else begin
      e_n      = SPD_W'(ea);
      prev_sel = SPD_W'(prev_a_r);
      i_sel    = integ_a_r;
      lim_s    = $signed({{(INT_W-LIM_W){1'b0}}, a_lim_r});
    end
    d_n   = (SPD_W+1)'(e_n) - (SPD_W+1)'(prev_sel);
    e_pos = !e_n[SPD_W-1] && (e_n != '0);
    hold  = ((i_sel > lim_s) && e_pos) || ((i_sel < -lim_s) && e_n[SPD_W-1]);
    i_sum = (INT_W+1)'(i_sel) + (INT_W+1)'(e_n);
    if (hold) i_n = i_sel;
    else begin
      case (i_sum[INT_W:INT_W-1])
        2'b01:   i_n = {1'b0, {(INT_W-1){1'b1}}};
        2'b10:   i_n = {1'b1, {(INT_W-1){1'b0}}};
        default: i_n = i_sum[INT_W-1:0];
      endcase
    end
  end

  // operand select for one partial product
  // step[2] picks the integral (four products), else step[1] picks e or d
  logic [SPD_W-1:0]   e_mag;
  logic [SPD_W:0]     d_abs;
  logic [INT_W-1:0]   i_abs;
  logic [GAIN_W-1:0]  gain;
  logic [CHUNK_G-1:0] g_chunk;
  logic [CHUNK_M-1:0] m_chunk;
  logic               op_neg, g_hi, m_hi;
  always_comb begin
    e_mag = e_r[SPD_W-1] ? SPD_W'(-e_r) : e_r;
    d_abs = d_r[SPD_W] ? (SPD_W+1)'(-d_r) : d_r;
    i_abs = i_r[INT_W-1] ? INT_W'(-i_r) : i_r;
    g_hi  = cmd.step[0];
    m_hi  = cmd.step[2] & cmd.step[1];
    if (cmd.step[2]) begin
      gain    = cmd.loop ? s_ki_r : a_ki_r;
      op_neg  = i_r[INT_W-1];
      m_chunk = m_hi ? {{(2*CHUNK_M-INT_W){1'b0}}, i_abs[INT_W-1:CHUNK_M]}
                     : i_abs[CHUNK_M-1:0];
    end else if (cmd.step[1]) begin
      gain    = cmd.loop ? s_kd_r : a_kd_r;
      op_neg  = d_r[SPD_W];
      m_chunk = d_abs[CHUNK_M-1:0];
    end else begin
      gain    = cmd.loop ? s_kp_r : a_kp_r;
      op_neg  = e_r[SPD_W-1];
      m_chunk = e_mag;
    end
    g_chunk = g_hi ? gain[GAIN_W-1:CHUNK_G] : gain[CHUNK_G-1:0];
  end

  // accumulate the registered product at its weight
  logic [ACC_W-1:0] pp_ext, pp_sh;
  always_comb begin
    pp_ext = {{(ACC_W-PP_W){1'b0}}, pp_r};
    case ({pp_ghi_r, pp_mhi_r})
      2'b00:   pp_sh = pp_ext;
      2'b01:   pp_sh = pp_ext << CHUNK_M;
      2'b10:   pp_sh = pp_ext << CHUNK_G;
      default: pp_sh = pp_ext << (CHUNK_G + CHUNK_M);
    endcase
  end

  // round half up to Q16.16 and clamp to the loop's output limit, SPD_LIM or DRV_LIM
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [VAL_W-1:0] v, lim_v, v_cl;
  always_comb begin
    acc_rnd = acc_r + (ACC_W'(1) << 31);
    v       = acc_rnd[ACC_W-1:32];
    lim_v   = cmd.loop ? VAL_W'(DRV_LIM) : VAL_W'(SPD_LIM);
    if (v > lim_v) v_cl = lim_v;
    else if (v < -lim_v) v_cl = -lim_v;
    else v_cl = v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_kp_r    <= RST_ANGLE_KP;
      a_ki_r    <= RST_ANGLE_KI;
      a_kd_r    <= RST_ANGLE_KD;
      a_lim_r   <= RST_ANGLE_LIM;
      s_kp_r    <= RST_SPEED_KP;
      s_ki_r    <= RST_SPEED_KI;
      s_kd_r    <= RST_SPEED_KD;
      s_lim_r   <= RST_SPEED_LIM;
      prev_a_r  <= '0;
      prev_s_r  <= '0;
      integ_a_r <= '0;
      integ_s_r <= '0;
      pp_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANGLE_KP:  a_kp_r  <= cfg_data;
          CFG_ANGLE_KI:  a_ki_r  <= cfg_data;
          CFG_ANGLE_KD:  a_kd_r  <= cfg_data;
          CFG_ANGLE_LIM: a_lim_r <= cfg_data[LIM_W-1:0];
          CFG_SPEED_KP:  s_kp_r  <= cfg_data;
          CFG_SPEED_KI:  s_ki_r  <= cfg_data;
          CFG_SPEED_KD:  s_kd_r  <= cfg_data;
          CFG_SPEED_LIM: s_lim_r <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        if (cmd.loop) begin
          prev_s_r  <= e_n;
          integ_s_r <= i_n;
        end else begin
          prev_a_r  <= e_n[EA_W-1:0];
          integ_a_r <= i_n;
        end
      end
      pp_vld_r <= cmd.mul_en;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tgt_r  <= in_target_angle;
      meas_r <= in_measured_angle;
      spd_r  <= in_measured_speed;
    end
    if (cmd.prep) begin
      e_r   <= e_n;
      d_r   <= d_n;
      i_r   <= i_n;
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= pp_neg_r ? acc_r - $signed(pp_sh) : acc_r + $signed(pp_sh);
    end
    if (cmd.mul_en) begin
      pp_r     <= g_chunk * m_chunk;
      pp_neg_r <= op_neg;
      pp_ghi_r <= g_hi;
      pp_mhi_r <= m_hi;
    end
    if (cmd.round) begin
      if (cmd.loop) dr_r <= v_cl[SPD_W-1:0];
      else st_r <= v_cl[ST_W-1:0];
    end
    if (cmd.load_out) begin
      out_drive_r <= dr_r;
      out_st_r    <= st_r;
    end
  end

  assign out_drive        = out_drive_r;
  assign out_speed_target = out_st_r;

endmodule

[tb/sv/cascade_pid_checker.sv]
// Checker for the cascade angle/speed PID block: tracks config writes, predicts each
// request's drive and speed target, and compares against the result channel.
// Depends on cas_pid_pkg.
module cascade_pid_checker import cas_pid_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [ANG_W-1:0] in_target_angle,
  input  logic signed [ANG_W-1:0] in_measured_angle,
  input  logic signed [SPD_W-1:0] in_measured_speed,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [SPD_W-1:0] out_drive,
  input  logic signed [ST_W-1:0]  out_speed_target,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data,
  output int                      mismatch_count,
  output int                      results_due
);

  localparam longint HALF_TURN = 64'sd11796480;    // 180 deg
  localparam longint FULL_TURN = 64'sd23592960;    // 360 deg
  localparam longint SPEED_CAP = 64'sd22937600;    // 350
  localparam longint DRIVE_CAP = 64'sd1638400000;  // 25000
  localparam longint INT48_HI  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INT48_LO  = -64'sh0000_8000_0000_0000;
  localparam longint ERR32_HI  = 64'sd2147483647;
  localparam longint ERR32_LO  = -64'sd2147483648;

  typedef struct {
    logic signed [SPD_W-1:0] drive;
    logic signed [ST_W-1:0]  speed_target;
  } pid_result_t;

  pid_result_t expected_results[$];

  logic [GAIN_W-1:0] ang_kp, ang_ki, ang_kd, spd_kp, spd_ki, spd_kd;
  logic [LIM_W-1:0]  ang_lim, spd_lim;
  longint ang_prev, ang_integ, spd_prev, spd_integ;

  function automatic logic signed [127:0] gain_term(logic [GAIN_W-1:0] g, longint x);
    logic signed [127:0] gs, xs;
    gs = {80'd0, g};
    xs = 128'(x);
    return gs * xs;
  endfunction

  // integrator with hold beyond the limit, saturating at 48 bits
  function automatic longint next_integral(longint integ, longint e, logic [LIM_W-1:0] lim);
    longint l, s;
    l = longint'(lim);
    if ((integ > l && e > 0) || (integ < -l && e < 0))
      return integ;
    s = integ + e;
    if (s > INT48_HI) s = INT48_HI;
    if (s < INT48_LO) s = INT48_LO;
    return s;
  endfunction

  // kp*e + ki*I + kd*d with 48 fraction bits, rounded half up to Q16.16, clamped
  function automatic longint loop_output(longint e, longint d, longint integ,
                                         logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                         logic [GAIN_W-1:0] kd, longint cap);
    logic signed [127:0] acc;
    acc = gain_term(kp, e) + gain_term(ki, integ) + gain_term(kd, d) + (128'sd1 <<< 31);
    acc = acc >>> 32;
    if (acc > 128'(cap)) return cap;
    if (acc < -128'(cap)) return -cap;
    return longint'(acc);
  endfunction

  always @(posedge clk) begin
    longint tgt, meas, gap, ea, da, st, es, ds, dr;
    pid_result_t exp_r;
    if (!rst_n) begin
      ang_kp = RST_ANGLE_KP;
      ang_ki = RST_ANGLE_KI;
      ang_kd = RST_ANGLE_KD;
      ang_lim = RST_ANGLE_LIM;
      spd_kp = RST_SPEED_KP;
      spd_ki = RST_SPEED_KI;
      spd_kd = RST_SPEED_KD;
      spd_lim = RST_SPEED_LIM;
      ang_prev = 0;
      ang_integ = 0;
      spd_prev = 0;
      spd_integ = 0;
      expected_results.delete();
    end else begin
      // an output at this edge always belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: expected none, got drive %0d speed_target %0d",
                   $time, out_drive, out_speed_target);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_drive !== exp_r.drive) begin
            mismatch_count++;
            $display("%0t drive mismatch: expected %0d, got %0d",
                     $time, exp_r.drive, out_drive);
          end
          if (out_speed_target !== exp_r.speed_target) begin
            mismatch_count++;
            $display("%0t speed_target mismatch: expected %0d, got %0d",
                     $time, exp_r.speed_target, out_speed_target);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_ANGLE_KP:  ang_kp = cfg_data;
          CFG_ANGLE_KI:  ang_ki = cfg_data;
          CFG_ANGLE_KD:  ang_kd = cfg_data;
          CFG_ANGLE_LIM: ang_lim = cfg_data[LIM_W-1:0];
          CFG_SPEED_KP:  spd_kp = cfg_data;
          CFG_SPEED_KI:  spd_ki = cfg_data;
          CFG_SPEED_KD:  spd_kd = cfg_data;
          CFG_SPEED_LIM: spd_lim = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        tgt = longint'(in_target_angle);
        meas = longint'(in_measured_angle);
        gap = tgt - meas;
        // single unwrap toward the target
        if (gap >= HALF_TURN)
          meas = meas + FULL_TURN;
        else if (gap <= -HALF_TURN)
          meas = meas - FULL_TURN;
        ea = tgt - meas;
        da = ea - ang_prev;
        ang_prev = ea;
        ang_integ = next_integral(ang_integ, ea, ang_lim);
        st = loop_output(ea, da, ang_integ, ang_kp, ang_ki, ang_kd, SPEED_CAP);

        es = st - longint'(in_measured_speed);
        if (es > ERR32_HI) es = ERR32_HI;
        if (es < ERR32_LO) es = ERR32_LO;
        ds = es - spd_prev;
        spd_prev = es;
        spd_integ = next_integral(spd_integ, es, spd_lim);
        dr = loop_output(es, ds, spd_integ, spd_kp, spd_ki, spd_kd, DRIVE_CAP);

        exp_r.drive = SPD_W'(dr);
        exp_r.speed_target = ST_W'(st);
        expected_results.push_back(exp_r);
      end
    end
    results_due = expected_results.size();
  end

endmodule

[tb/sv/cascade_angle_speed_pid_tb.sv]
// Testbench top for cascade_angle_speed_pid: clock, reset, config phases, directed and
// random requests with sender gaps and receiver stalls; verdict from cascade_pid_checker.
// Depends on cas_pid_pkg, cascade_angle_speed_pid and cascade_pid_checker.
module cascade_angle_speed_pid_tb;
  import cas_pid_pkg::*;

  localparam int ONE_DEG     = 65536;
  localparam int ANGLE_SPAN  = 720 * ONE_DEG;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_TAIL  = 48;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 220;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [ANG_W-1:0] in_target_angle = '0;
  logic signed [ANG_W-1:0] in_measured_angle = '0;
  logic signed [SPD_W-1:0] in_measured_speed = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SPD_W-1:0] out_drive;
  logic signed [ST_W-1:0]  out_speed_target;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [GAIN_W-1:0]       cfg_data = '0;

  int mismatch_count;
  int results_due;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int setpoint = 0;

  cascade_angle_speed_pid u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_target_angle  (in_target_angle),
    .in_measured_angle(in_measured_angle),
    .in_measured_speed(in_measured_speed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_speed_target (out_speed_target),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cascade_pid_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_target_angle  (in_target_angle),
    .in_measured_angle(in_measured_angle),
    .in_measured_speed(in_measured_speed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_speed_target (out_speed_target),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** cascade_angle_speed_pid: FAILED **");
    $finish;
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain(int lo_shift, int hi_shift);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return GAIN_W'(raw) >> $urandom_range(hi_shift, lo_shift);
  endfunction

  // upper data bits are random; only the low LIM_W bits land in the register
  function automatic logic [GAIN_W-1:0] rand_limit(int lo_shift, int hi_shift);
    logic [GAIN_W-1:0] raw;
    raw = GAIN_W'({$urandom, $urandom});
    return {raw[GAIN_W-1:LIM_W], raw[LIM_W-1:0] >> $urandom_range(hi_shift, lo_shift)};
  endfunction

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 52; stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  stall_pct = 52; end
      IDLE_BOTH: begin send_gap_pct = 31; stall_pct = 31; end
      default:   begin send_gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // called and returns at a falling edge; valid is left high on return, until a send gap drops it
  task automatic send_request(logic signed [ANG_W-1:0] tgt, logic signed [ANG_W-1:0] meas,
                              logic signed [SPD_W-1:0] spd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_angle <= tgt;
    in_measured_angle <= meas;
    in_measured_speed <= spd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_registers(logic [GAIN_W-1:0] regs [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= regs[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_phase_gains(int phase);
    logic [GAIN_W-1:0] regs [8];
    regs[CFG_ANGLE_KP]  = RST_ANGLE_KP;
    regs[CFG_ANGLE_KI]  = RST_ANGLE_KI;
    regs[CFG_ANGLE_KD]  = RST_ANGLE_KD;
    regs[CFG_ANGLE_LIM] = GAIN_W'(RST_ANGLE_LIM);
    regs[CFG_SPEED_KP]  = RST_SPEED_KP;
    regs[CFG_SPEED_KI]  = RST_SPEED_KI;
    regs[CFG_SPEED_KD]  = RST_SPEED_KD;
    regs[CFG_SPEED_LIM] = GAIN_W'(RST_SPEED_LIM);
    case (phase)
      2: begin  // everything at its maximum
        foreach (regs[i]) regs[i] = '1;
      end
      3: begin
        foreach (regs[i]) regs[i] = '0;
      end
      4: begin  // zero limits: integral held while its error pushes it further off zero
        regs[CFG_ANGLE_KI]  = rand_gain(12, 20);
        regs[CFG_SPEED_KI]  = rand_gain(12, 20);
        regs[CFG_ANGLE_LIM] = '0;
        regs[CFG_SPEED_LIM] = '0;
      end
      5: begin
        foreach (regs[i]) regs[i] = rand_gain(0, 47);
        regs[CFG_ANGLE_LIM] = rand_limit(0, 30);
        regs[CFG_SPEED_LIM] = rand_limit(0, 30);
      end
      6: ;      // reset values written back
      7: begin  // strong integral, small limits: hold path hit often
        regs[CFG_ANGLE_KP]  = rand_gain(10, 20);
        regs[CFG_SPEED_KP]  = rand_gain(10, 20);
        regs[CFG_ANGLE_KI]  = rand_gain(8, 16);
        regs[CFG_SPEED_KI]  = rand_gain(8, 16);
        regs[CFG_ANGLE_LIM] = rand_limit(8, 24);
        regs[CFG_SPEED_LIM] = rand_limit(8, 24);
      end
      default: begin
        regs[CFG_ANGLE_KP]  = rand_gain(8, 20);
        regs[CFG_ANGLE_KI]  = rand_gain(20, 40);
        regs[CFG_ANGLE_KD]  = rand_gain(8, 20);
        regs[CFG_ANGLE_LIM] = rand_limit(0, 16);
        regs[CFG_SPEED_KP]  = rand_gain(8, 20);
        regs[CFG_SPEED_KI]  = rand_gain(20, 40);
        regs[CFG_SPEED_KD]  = rand_gain(8, 20);
        regs[CFG_SPEED_LIM] = rand_limit(0, 16);
      end
    endcase
    write_registers(regs);
  endtask

  task automatic random_request();
    int pick, tgt, meas, spd, sgn;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // tracking a held setpoint that moves now and then
      if ($urandom_range(19) == 0) setpoint = span(-ANGLE_SPAN, ANGLE_SPAN);
      tgt = setpoint;
      meas = setpoint + span(-20 * ONE_DEG, 20 * ONE_DEG);
      spd = span(-2000 * ONE_DEG, 2000 * ONE_DEG);
    end else if (pick < 75) begin
      // gap near a multiple of half a turn, around the unwrap thresholds
      sgn = $urandom_range(1) ? 1 : -1;
      tgt = span(-360 * ONE_DEG, 360 * ONE_DEG);
      meas = tgt - sgn * int'($urandom_range(3, 1)) * 180 * ONE_DEG + span(-2, 2);
      spd = span(-2000 * ONE_DEG, 2000 * ONE_DEG);
    end else if (pick < 95) begin
      tgt = span(-ANGLE_SPAN, ANGLE_SPAN);
      meas = span(-ANGLE_SPAN, ANGLE_SPAN);
      spd = $urandom_range(1) ? int'($urandom) : span(-2000 * ONE_DEG, 2000 * ONE_DEG);
    end else begin
      // raw bits: angles past +-720 deg and any speed
      tgt = int'($urandom);
      meas = int'($urandom);
      spd = int'($urandom);
    end
    send_request(ANG_W'(tgt), ANG_W'(meas), spd);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests at reset gains
    set_idling(IDLE_NONE);
    send_request(0, 0, 0);
    send_request(ANG_W'(ANGLE_SPAN), ANG_W'(-ANGLE_SPAN), 0);
    send_request(ANG_W'(-ANGLE_SPAN), ANG_W'(ANGLE_SPAN), 0);
    send_request(ANG_W'(90 * ONE_DEG), ANG_W'(-90 * ONE_DEG), 0);
    send_request(ANG_W'(-90 * ONE_DEG), ANG_W'(90 * ONE_DEG), 0);
    send_request(ANG_W'(180 * ONE_DEG - 1), 0, 0);
    send_request(0, ANG_W'(180 * ONE_DEG - 1), 0);
    send_request(27'sh3FF_FFFF, -27'sh400_0000, 0);
    send_request(-27'sh400_0000, 27'sh3FF_FFFF, 0);
    send_request(0, 0, 32'sh8000_0000);            // speed error overflows high
    send_request(ANG_W'(-100 * ONE_DEG), 0, 32'sh7FFF_FFFF);  // and low
    send_request(0, 0, -1);
    send_request(0, 0, 1);
    send_request(1, 0, 32'sh5555_5555);
    send_request(-1, 0, -32'sh2AAA_AAAB);
    for (int i = 0; i < 8; i++)
      send_request(ANG_W'(700 * ONE_DEG), ANG_W'(-10 * ONE_DEG), 0);
    send_request(0, 0, 0);
    in_valid <= 1'b0;

    for (int phase = 1; phase <= PHASES; phase++) begin
      wait_drained();
      load_phase_gains(phase);
      set_idling(idle_mode_t'(phase % 4));
      for (int n = 0; n < PHASE_ITEMS; n++)
        random_request();
      in_valid <= 1'b0;
    end

    set_idling(IDLE_NONE);
    wait_drained();
    if (mismatch_count == 0 && results_due == 0)
      $display("** cascade_angle_speed_pid: PASSED **");
    else
      $display("** cascade_angle_speed_pid: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hdl/cas_pid_pkg.sv
hdl/cas_pid_ctrl.sv
hdl/cas_pid_dp.sv
hdl/cascade_angle_speed_pid.sv
tb/sv/cascade_pid_checker.sv
tb/sv/cascade_angle_speed_pid_tb.sv
